FILE: src/mcv_pkg.sv
// shared types and constants of the mecanum chassis velocity controller
package mcv_pkg;

  localparam int WHEELS    = 4;
  localparam int CMD_W     = 11;
  localparam int SPD_W     = 16;
  localparam int DRV_W     = 16;
  localparam int TGT_W     = 13;
  localparam int GAIN_W    = 16;
  localparam int POL_W     = 2;
  localparam int LIM_W     = 15;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 16;

  // lane pipeline depth and the stage that owns the per-wheel state
  localparam int NSTG      = 11;
  localparam int STATE_STG = 5;

  localparam logic [CFG_AW-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_POLARITY    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DRIVE_LIMIT = 3'd4;

  typedef logic signed [TGT_W-1:0] tgt_t;
  typedef logic signed [SPD_W-1:0] spd_t;
  typedef logic signed [DRV_W-1:0] drv_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [POL_W-1:0]  polarity;
    logic [LIM_W-1:0]         drive_limit;
  } cfg_t;

  typedef struct packed {
    logic [NSTG-1:0] adv;
    logic            upd;
  } ctl_t;

endpackage

FILE: src/mcv_mix.sv
// mecanum mixing of drive, strafe and rotate into four wheel targets
module mcv_mix import mcv_pkg::*; (
  input  logic signed [CMD_W-1:0] drive_cmd,
  input  logic signed [CMD_W-1:0] strafe_cmd,
  input  logic signed [CMD_W-1:0] rotate_cmd,
  output tgt_t                    tgt [WHEELS]
);

  tgt_t d;
  tgt_t s;
  tgt_t r;

  always_comb begin
    d = TGT_W'(drive_cmd);
    s = TGT_W'(strafe_cmd);
    r = TGT_W'(rotate_cmd);
    tgt[0] = d + s + r;
    tgt[1] = d - s + r;
    tgt[2] = r - d - s;
    tgt[3] = s + r - d;
  end

endmodule

FILE: src/mcv_lane.sv
// one wheel lane: target scaling, error, integrator and pid weighting with clamp
module mcv_lane import mcv_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SUM_WIDTH      = 40
) (
  input  logic clk,
  input  logic rst_n,
  input  ctl_t ctl,
  input  cfg_t cfg,
  input  tgt_t tgt,
  input  spd_t speed,
  output drv_t drive
);

  localparam int LO  = SUM_WIDTH / 2;
  localparam int HI  = SUM_WIDTH - LO;
  localparam int PLW = GAIN_W + LO + 1;
  localparam int PHW = GAIN_W + HI;
  localparam int PW  = GAIN_W + SUM_WIDTH;
  localparam int XW  = (PW > 66) ? PW : 66;
  localparam int VW  = 66;

  // (t + 660) * 16342 / 1320 done as (|num| >> 3) / 165 via reciprocal
  localparam logic [25:0] SCALE_NUM = 26'd16342;
  localparam logic [46:0] RECIP     = 47'd13015053;
  localparam logic signed [13:0] IN_OFS  = 14'sd660;
  localparam logic signed [17:0] OUT_OFS = 18'sd8171;
  localparam logic signed [18:0] ERR_HI  = 19'sd65535;
  localparam logic signed [18:0] ERR_LO  = -19'sd65536;

  localparam logic signed [SUM_WIDTH:0] SUM_HI =
    (SUM_WIDTH+1)'({1'b0, {(SUM_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_WIDTH:0] SUM_LO = ~SUM_HI;
  localparam logic signed [XW-1:0] SAT_HI = XW'(64'sh7FFF_FFFF_FFFF_FFFF);
  localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [63:0] sat64(input logic signed [XW-1:0] x);
    logic signed [63:0] y;
    if (x > SAT_HI) begin
      y = SAT_HI[63:0];
    end else if (x < SAT_LO) begin
      y = SAT_LO[63:0];
    end else begin
      y = x[63:0];
    end
    return y;
  endfunction

  // stage payload registers
  logic                     neg0_r, neg1_r, neg2_r;
  logic [11:0]              au_r;
  logic [22:0]              x_r;
  logic [15:0]              qm_r;
  spd_t                     spd0_r, spd1_r, spd2_r, spd3_r;
  logic signed [17:0]       t_r;
  logic signed [16:0]       e_r;
  logic signed [17:0]       de_r;
  logic signed [32:0]       pe_r, pe7_r;
  logic signed [PLW-1:0]    pl_r;
  logic signed [PHW-1:0]    ph_r;
  logic signed [33:0]       dd_r, dd7_r, dd8_r;
  logic signed [63:0]       pis_r, a2_r, a3_r;
  logic signed [VW-1:0]     pv_r;

  // per-wheel state
  logic signed [SUM_WIDTH-1:0] sum_r;
  logic signed [16:0]          last_r;

  logic signed [13:0]       u;
  logic [25:0]              prod_s;
  logic [46:0]              prod_q;
  logic signed [17:0]       tq;
  logic signed [18:0]       diff;
  logic signed [16:0]       e_nxt;
  logic signed [SUM_WIDTH:0] sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_nxt;
  logic signed [XW-1:0]     pi_full;
  logic signed [63:0]       sh;
  logic signed [VW-1:0]     base;
  logic signed [VW-1:0]     pv_nxt;
  logic signed [VW-1:0]     lim;

  always_comb begin
    u      = 14'(tgt) + IN_OFS;
    prod_s = 26'(au_r) * SCALE_NUM;
    prod_q = 47'(x_r) * RECIP;
    tq     = $signed({2'b00, qm_r});
    diff   = 19'(t_r) - 19'(spd3_r);
    if (diff > ERR_HI) begin
      e_nxt = ERR_HI[16:0];
    end else if (diff < ERR_LO) begin
      e_nxt = ERR_LO[16:0];
    end else begin
      e_nxt = diff[16:0];
    end
    sum_wide = (SUM_WIDTH+1)'(sum_r) + (SUM_WIDTH+1)'(e_r);
    if (sum_wide > SUM_HI) begin
      sum_nxt = SUM_HI[SUM_WIDTH-1:0];
    end else if (sum_wide < SUM_LO) begin
      sum_nxt = SUM_LO[SUM_WIDTH-1:0];
    end else begin
      sum_nxt = sum_wide[SUM_WIDTH-1:0];
    end
    pi_full = (XW'(ph_r) <<< LO) + XW'(pl_r);
    sh      = a3_r >>> GAIN_FRAC_BITS;
    // polarity is -2, -1, 0 or +1
    if (cfg.polarity == '0) begin
      base = '0;
    end else if (cfg.polarity[0]) begin
      base = VW'(sh);
    end else begin
      base = VW'(sh) <<< 1;
    end
    pv_nxt = cfg.polarity[1] ? -base : base;
    lim    = $signed({{(VW-LIM_W){1'b0}}, cfg.drive_limit});
    if (pv_r > lim) begin
      drive = lim[DRV_W-1:0];
    end else if (pv_r < -lim) begin
      drive = -lim[DRV_W-1:0];
    end else begin
      drive = pv_r[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      neg0_r <= u[13];
      au_r   <= u[13] ? 12'(-u) : 12'(u);
      spd0_r <= speed;
    end
    if (ctl.adv[1]) begin
      x_r    <= prod_s[25:3];
      neg1_r <= neg0_r;
      spd1_r <= spd0_r;
    end
    if (ctl.adv[2]) begin
      qm_r   <= prod_q[46:31];
      neg2_r <= neg1_r;
      spd2_r <= spd1_r;
    end
    if (ctl.adv[3]) begin
      t_r    <= (neg2_r ? -tq : tq) - OUT_OFS;
      spd3_r <= spd2_r;
    end
    if (ctl.adv[4]) begin
      e_r <= e_nxt;
    end
    if (ctl.upd) begin
      de_r <= 18'(e_r) - 18'(last_r);
    end
    if (ctl.adv[6]) begin
      pe_r <= 33'(cfg.gain_p) * 33'(last_r);
      pl_r <= PLW'(cfg.gain_i) * PLW'($signed({1'b0, sum_r[LO-1:0]}));
      ph_r <= PHW'(cfg.gain_i) * PHW'($signed(sum_r[SUM_WIDTH-1:LO]));
      dd_r <= 34'(cfg.gain_d) * 34'(de_r);
    end
    if (ctl.adv[7]) begin
      pis_r <= sat64(pi_full);
      pe7_r <= pe_r;
      dd7_r <= dd_r;
    end
    if (ctl.adv[8]) begin
      a2_r  <= sat64(XW'(pe7_r) + XW'(pis_r));
      dd8_r <= dd7_r;
    end
    if (ctl.adv[9]) begin
      a3_r <= sat64(XW'(a2_r) + XW'(dd8_r));
    end
    if (ctl.adv[10]) begin
      pv_r <= pv_nxt;
    end
  end

  // integrator and previous error, touched once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      last_r <= '0;
    end else if (ctl.upd) begin
      sum_r  <= sum_nxt;
      last_r <= e_r;
    end
  end

endmodule

FILE: src/mecanum_chassis_velocity_pid.sv
// top level: config registers, lane control, four wheel lanes and output register
//
// Mecanum chassis velocity controller. One input transaction carries the
// drive, strafe and rotate commands and the four measured wheel speeds; one
// output transaction carries the four clamped wheel drive commands.
// Both channels use valid/ready. Four identical lanes, one per wheel, run
// an 11-stage pipeline (scale, error, integrator, gain products, saturating
// sums, shift and polarity); the output register merges the four lanes.
// Each transaction passes the lane stages and then the output register before out_valid rises.
// Throughput: one transaction per cycle unless out_ready stalls the output;
// every lane stage, including the integrator update, is fully pipelined.
// Stalls: each stage holds when it is full and the stage after it holds;
// in_ready stays high while any stage up to the output register has room,
// so new input is taken while a finished result waits for out_ready.
// Reset (rst_n low, synchronous): pipeline emptied, integrators and
// previous errors cleared, gains 0, polarity +1, drive limit 32767.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 gain_p,
// 1 gain_i, 2 gain_d, 3 polarity, 4 drive_limit); other indexes are ignored.
// Write only while no transaction is in flight.
module mecanum_chassis_velocity_pid import mcv_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SUM_WIDTH      = 40
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [CMD_W-1:0] in_drive_cmd,
  input  logic signed [CMD_W-1:0] in_strafe_cmd,
  input  logic signed [CMD_W-1:0] in_rotate_cmd,
  input  logic signed [SPD_W-1:0] in_speed_wheel_a,
  input  logic signed [SPD_W-1:0] in_speed_wheel_b,
  input  logic signed [SPD_W-1:0] in_speed_wheel_c,
  input  logic signed [SPD_W-1:0] in_speed_wheel_d,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DRV_W-1:0] out_drive_wheel_a,
  output logic signed [DRV_W-1:0] out_drive_wheel_b,
  output logic signed [DRV_W-1:0] out_drive_wheel_c,
  output logic signed [DRV_W-1:0] out_drive_wheel_d,
  input  logic                    cfg_we,
  input  logic [CFG_AW-1:0]       cfg_addr,
  input  logic [CFG_DW-1:0]       cfg_wdata
);

  cfg_t            cfg_r;
  ctl_t            ctl;
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;
  logic            out_valid_r;
  tgt_t            tgt [WHEELS];
  spd_t            spd [WHEELS];
  drv_t            drv [WHEELS];
  drv_t            drv_r [WHEELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= '0;
      cfg_r.gain_i      <= '0;
      cfg_r.gain_d      <= '0;
      cfg_r.polarity    <= 2'sb01;
      cfg_r.drive_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GAIN_P:      cfg_r.gain_p      <= cfg_wdata;
        REG_GAIN_I:      cfg_r.gain_i      <= cfg_wdata;
        REG_GAIN_D:      cfg_r.gain_d      <= cfg_wdata;
        REG_POLARITY:    cfg_r.polarity    <= cfg_wdata[POL_W-1:0];
        REG_DRIVE_LIMIT: cfg_r.drive_limit <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when it or any later stage has a bubble, or the output register can take a result
  assign rdy[NSTG] = !out_valid_r || out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = rdy[NSTG] || !(&v_r[NSTG-1:k]);
  end

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
    ctl.adv = rdy[NSTG-1:0];
    ctl.upd = rdy[STATE_STG] && v_r[STATE_STG-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      if (rdy[NSTG]) begin
        out_valid_r <= v_r[NSTG-1];
      end
    end
  end

  assign in_ready = rdy[0];

  mcv_mix u_mix (
    .drive_cmd  (in_drive_cmd),
    .strafe_cmd (in_strafe_cmd),
    .rotate_cmd (in_rotate_cmd),
    .tgt        (tgt)
  );

  assign spd[0] = in_speed_wheel_a;
  assign spd[1] = in_speed_wheel_b;
  assign spd[2] = in_speed_wheel_c;
  assign spd[3] = in_speed_wheel_d;

  for (genvar w = 0; w < WHEELS; w++) begin : g_lane
    mcv_lane #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .SUM_WIDTH      (SUM_WIDTH)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .cfg   (cfg_r),
      .tgt   (tgt[w]),
      .speed (spd[w]),
      .drive (drv[w])
    );
  end

  // merge stage: the four lane results form one output transaction
  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      for (int w = 0; w < WHEELS; w++) begin
        drv_r[w] <= drv[w];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_wheel_a = drv_r[0];
  assign out_drive_wheel_b = drv_r[1];
  assign out_drive_wheel_c = drv_r[2];
  assign out_drive_wheel_d = drv_r[3];

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline full and output stalled");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-1] && rdy[NSTG]) |=> out_valid_r)
    else $error("last lane stage result lost at the output register");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> ((v_r == '0) && !out_valid_r))
    else $error("pipeline not empty after reset");

endmodule
